/* src/psic_pkg.sv */
// psic_pkg: shared types and constants of the polygon self-intersection checker
// no dependencies

package psic_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int MAX_REPORTED_PAIRS = 63;
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = IDX_W + 1;
    localparam int PAIR_W = 15;
    localparam logic [PAIR_W-1:0] PAIR_MAX = '1;
    localparam int RPT_W = 6;

    localparam logic [0:0] CFG_REPORT_ALL = 1'd0;
    localparam logic [0:0] CFG_THRESHOLD = 1'd1;

    localparam logic [2:0] KIND_PAIR = 3'd0;
    localparam logic [2:0] KIND_SIMPLE = 3'd1;
    localparam logic [2:0] KIND_CROSSING = 3'd2;
    localparam logic [2:0] KIND_TOO_FEW = 3'd3;
    localparam logic [2:0] KIND_TOO_MANY = 3'd4;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_FETCH,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_MUL,
        ST_SUB,
        ST_DECIDE,
        ST_NEXT,
        ST_EMIT_PAIR,
        ST_EMIT_STATUS
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic store_vertex;
        logic clear_poly;
        logic set_too_many;
        logic init_pairs;
        logic [1:0] rd_sel;
        logic mul_en;
        logic sub_en;
        logic decide_en;
        logic step_pair;
        logic load_pair_out;
        logic load_status_out;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic store_full;
        logic too_many;
        logic too_few;
        logic pair_done;
        logic pair_skip;
        logic crosses;
        logic cap_reached;
        logic out_busy;
    } stat_t;

endpackage

/* src/polygon_self_intersection_checker_core.sv */
// polygon_self_intersection_checker_core: top level of the polygon crossing checker
// depends on psic_pkg, psic_ctrl, psic_dp (and psic_ram through psic_dp)
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+----------------------------------
//  in      | in        | in_valid / in_stall  | x_coord, y_coord, final_vertex
//  out     | out       | out_valid / out_stall| kind, a/b indices, pair_count, last
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// vertex words are taken back to back while loading; after the final word the input stalls
// while the controller steps through the edge pairs: adjacent pairs are stepped over with no
// reads, and each tested pair takes four reads of the single-port vertex rams, a wait for
// the last read to land, then multiply, subtract, compare and step
// reset clears the controller and counters; vertex rams need no clearing pass
// a stalled output word holds, and the pair sweep waits while it is stalled and a new word is ready

module polygon_self_intersection_checker_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [31:0]          x_coord,
    input  logic signed [31:0]          y_coord,
    input  logic                        final_vertex,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  kind,
    output logic [7:0]                  a_start,
    output logic [7:0]                  a_end,
    output logic [7:0]                  b_start,
    output logic [7:0]                  b_end,
    output logic [14:0]                 pair_count,
    output logic                        last_result,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [31:0]                 cfg_data
);

    // configuration registers
    logic        report_all_reg;
    logic [31:0] threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_all_reg <= 1'b1;
            threshold_reg  <= 32'd43;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                psic_pkg::CFG_REPORT_ALL: report_all_reg <= cfg_data[0];
                psic_pkg::CFG_THRESHOLD:  threshold_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    psic_pkg::ctrl_t ctrl;
    psic_pkg::stat_t stat;

    // sequencer
    psic_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .final_vertex (final_vertex),
        .report_all   (report_all_reg),
        .stat         (stat),
        .in_stall     (in_stall),
        .ctrl         (ctrl)
    );

    // storage, arithmetic and output word
    psic_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctrl               (ctrl),
        .x_coord            (x_coord),
        .y_coord            (y_coord),
        .parallel_threshold (threshold_reg),
        .out_stall          (out_stall),
        .stat               (stat),
        .out_valid          (out_valid),
        .kind               (kind),
        .a_start            (a_start),
        .a_end              (a_end),
        .b_start            (b_start),
        .b_end              (b_end),
        .pair_count         (pair_count),
        .last_result        (last_result)
    );

endmodule

/* src/psic_ram.sv */
// psic_ram: generic single-port ram with registered read
// no dependencies

module psic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* src/psic_ctrl.sv */
// psic_ctrl: sequencer for vertex load, pair tests and result output
// depends on psic_pkg

module psic_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             final_vertex,
    input  logic             report_all,
    input  psic_pkg::stat_t  stat,
    output logic             in_stall,
    output psic_pkg::ctrl_t  ctrl
);

    psic_pkg::state_t state_reg;
    psic_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psic_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        in_stall = 1'b1;
        case (state_reg)
            psic_pkg::ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (stat.store_full)
                    begin
                        ctrl.set_too_many = 1'b1;
                    end
                    else
                    begin
                        ctrl.store_vertex = 1'b1;
                    end
                    if (final_vertex)
                    begin
                        state_next = psic_pkg::ST_START;
                    end
                end
            end
            psic_pkg::ST_START:
            begin
                ctrl.init_pairs = 1'b1;
                if (stat.too_many || stat.too_few)
                begin
                    state_next = psic_pkg::ST_EMIT_STATUS;
                end
                else
                begin
                    state_next = psic_pkg::ST_FETCH;
                end
            end
            psic_pkg::ST_FETCH:
            begin
                if (stat.pair_done)
                begin
                    state_next = psic_pkg::ST_EMIT_STATUS;
                end
                else if (stat.pair_skip)
                begin
                    ctrl.step_pair = 1'b1;
                end
                else
                begin
                    ctrl.rd_sel = 2'd0;
                    state_next = psic_pkg::ST_RD0;
                end
            end
            psic_pkg::ST_RD0:
            begin
                ctrl.rd_sel = 2'd1;
                state_next = psic_pkg::ST_RD1;
            end
            psic_pkg::ST_RD1:
            begin
                ctrl.rd_sel = 2'd2;
                state_next = psic_pkg::ST_RD2;
            end
            psic_pkg::ST_RD2:
            begin
                ctrl.rd_sel = 2'd3;
                state_next = psic_pkg::ST_RD3;
            end
            psic_pkg::ST_RD3:
            begin
                // last read word lands in the capture registers
                state_next = psic_pkg::ST_MUL;
            end
            psic_pkg::ST_MUL:
            begin
                ctrl.mul_en = 1'b1;
                state_next = psic_pkg::ST_SUB;
            end
            psic_pkg::ST_SUB:
            begin
                ctrl.sub_en = 1'b1;
                state_next = psic_pkg::ST_DECIDE;
            end
            psic_pkg::ST_DECIDE:
            begin
                ctrl.decide_en = 1'b1;
                state_next = psic_pkg::ST_NEXT;
            end
            psic_pkg::ST_NEXT:
            begin
                if (!stat.crosses)
                begin
                    ctrl.step_pair = 1'b1;
                    state_next = psic_pkg::ST_FETCH;
                end
                else if (report_all && stat.cap_reached)
                begin
                    ctrl.step_pair = 1'b1;
                    state_next = psic_pkg::ST_FETCH;
                end
                else
                begin
                    state_next = psic_pkg::ST_EMIT_PAIR;
                end
            end
            psic_pkg::ST_EMIT_PAIR:
            begin
                if (!stat.out_busy)
                begin
                    ctrl.load_pair_out = 1'b1;
                    if (report_all)
                    begin
                        ctrl.step_pair = 1'b1;
                        state_next = psic_pkg::ST_FETCH;
                    end
                    else
                    begin
                        state_next = psic_pkg::ST_EMIT_STATUS;
                    end
                end
            end
            psic_pkg::ST_EMIT_STATUS:
            begin
                if (!stat.out_busy)
                begin
                    ctrl.load_status_out = 1'b1;
                    ctrl.clear_poly = 1'b1;
                    state_next = psic_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = psic_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

/* src/psic_dp.sv */
// psic_dp: vertex stores, pair indices, exact crossing arithmetic, output register
// depends on psic_pkg and psic_ram

module psic_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  psic_pkg::ctrl_t                      ctrl,
    input  logic signed [31:0]                   x_coord,
    input  logic signed [31:0]                   y_coord,
    input  logic [31:0]                          parallel_threshold,
    input  logic                                 out_stall,
    output psic_pkg::stat_t                      stat,
    output logic                                 out_valid,
    output logic [2:0]                           kind,
    output logic [7:0]                           a_start,
    output logic [7:0]                           a_end,
    output logic [7:0]                           b_start,
    output logic [7:0]                           b_end,
    output logic [psic_pkg::PAIR_W-1:0]          pair_count,
    output logic                                 last_result
);

    localparam int IW = psic_pkg::IDX_W;
    localparam int CW = psic_pkg::CNT_W;
    localparam int PW = psic_pkg::PAIR_W;
    localparam int RW = psic_pkg::RPT_W;

    logic [CW-1:0] total_reg;
    logic          too_many_reg;
    logic [CW-1:0] a0_reg;
    logic [CW-1:0] b0_reg;
    logic [PW-1:0] cnt_reg;
    logic [RW-1:0] rpt_reg;
    logic          cross_reg;

    // pair indices
    logic [CW-1:0] a1;
    logic [CW-1:0] b1;
    logic [CW-1:0] b0_next_cnt;
    logic [CW-1:0] a0_next_cnt;
    always_comb
    begin
        a1 = a0_reg + CW'(1);
        b1 = (b0_reg == total_reg - CW'(1)) ? '0 : b0_reg + CW'(1);
        b0_next_cnt = b0_reg + CW'(1);
        a0_next_cnt = a0_reg + CW'(1);
    end

    // memory address mux
    logic [IW-1:0] addr;
    logic          we;
    always_comb
    begin
        we = ctrl.store_vertex;
        if (ctrl.store_vertex)
        begin
            addr = total_reg[IW-1:0];
        end
        else
        begin
            case (ctrl.rd_sel)
                2'd0: addr = a0_reg[IW-1:0];
                2'd1: addr = a1[IW-1:0];
                2'd2: addr = b0_reg[IW-1:0];
                default: addr = b1[IW-1:0];
            endcase
        end
    end

    logic [31:0] xr;
    logic [31:0] yr;

    psic_ram #(.WIDTH(32), .DEPTH(psic_pkg::MAX_VERTICES)) u_ram_x (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (x_coord),
        .rdata (xr)
    );

    psic_ram #(.WIDTH(32), .DEPTH(psic_pkg::MAX_VERTICES)) u_ram_y (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (y_coord),
        .rdata (yr)
    );

    // vertex capture: read data lands in the cycle after each address
    // idle cycles re-read vertex a0 into slot 0, which leaves it unchanged
    logic signed [31:0] vx_reg [4];
    logic signed [31:0] vy_reg [4];
    logic [1:0] cap_sel_reg;
    logic       cap_en_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_en_reg  <= 1'b0;
            cap_sel_reg <= '0;
        end
        else
        begin
            cap_en_reg  <= !ctrl.store_vertex;
            cap_sel_reg <= ctrl.rd_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_en_reg)
        begin
            vx_reg[cap_sel_reg] <= xr;
            vy_reg[cap_sel_reg] <= yr;
        end
    end

    // differences, 33 bit signed
    logic signed [32:0] ax, ay, bx, by, cx, cy;
    always_comb
    begin
        ax = 33'(vx_reg[1]) - 33'(vx_reg[0]);
        ay = 33'(vy_reg[1]) - 33'(vy_reg[0]);
        bx = 33'(vx_reg[3]) - 33'(vx_reg[2]);
        by = 33'(vy_reg[3]) - 33'(vy_reg[2]);
        cx = 33'(vx_reg[0]) - 33'(vx_reg[2]);
        cy = 33'(vy_reg[0]) - 33'(vy_reg[2]);
    end

    // six 33x33 products in one step, registered
    logic signed [65:0] p_reg [6];
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            p_reg[0] <= ax * by;
            p_reg[1] <= bx * ay;
            p_reg[2] <= ax * cy;
            p_reg[3] <= cx * ay;
            p_reg[4] <= bx * cy;
            p_reg[5] <= by * cx;
        end
    end

    logic signed [67:0] det_reg, nb_reg, na_reg;
    always_ff @(posedge clk)
    begin
        if (ctrl.sub_en)
        begin
            det_reg <= 68'(p_reg[0]) - 68'(p_reg[1]);
            nb_reg  <= 68'(p_reg[2]) - 68'(p_reg[3]);
            na_reg  <= 68'(p_reg[4]) - 68'(p_reg[5]);
        end
    end

    // sign normalize and compare
    logic signed [67:0] d, nb, na;
    logic               hit;
    always_comb
    begin
        if (det_reg < 0)
        begin
            d  = -det_reg;
            nb = -nb_reg;
            na = -na_reg;
        end
        else
        begin
            d  = det_reg;
            nb = nb_reg;
            na = na_reg;
        end
        hit = (d != 0) && (d >= $signed({36'd0, parallel_threshold}))
              && (nb >= 0) && (nb <= d) && (na >= 0) && (na <= d);
    end

    // output register
    logic        ov_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  as_reg, ae_reg, bs_reg, be_reg;
    logic [PW-1:0] pc_reg;
    logic        last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            too_many_reg <= 1'b0;
            a0_reg       <= '0;
            b0_reg       <= '0;
            cnt_reg      <= '0;
            rpt_reg      <= '0;
            cross_reg    <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (ctrl.load_pair_out || ctrl.load_status_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            if (ctrl.store_vertex)
            begin
                total_reg <= total_reg + CW'(1);
            end
            if (ctrl.set_too_many)
            begin
                too_many_reg <= 1'b1;
            end
            if (ctrl.init_pairs)
            begin
                a0_reg  <= '0;
                b0_reg  <= CW'(2);
                cnt_reg <= '0;
                rpt_reg <= '0;
            end
            if (ctrl.decide_en)
            begin
                cross_reg <= hit;
                if (hit && cnt_reg != psic_pkg::PAIR_MAX)
                begin
                    cnt_reg <= cnt_reg + PW'(1);
                end
            end
            if (ctrl.step_pair)
            begin
                cross_reg <= 1'b0;
                if (b0_next_cnt >= total_reg)
                begin
                    a0_reg <= a0_next_cnt;
                    b0_reg <= a0_reg + CW'(3);
                end
                else
                begin
                    b0_reg <= b0_next_cnt;
                end
            end
            if (ctrl.load_pair_out)
            begin
                rpt_reg <= rpt_reg + RW'(1);
            end
            if (ctrl.clear_poly)
            begin
                total_reg    <= '0;
                too_many_reg <= 1'b0;
                cnt_reg      <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_pair_out)
        begin
            kind_reg <= psic_pkg::KIND_PAIR;
            as_reg   <= a0_reg[7:0];
            ae_reg   <= a1[7:0];
            bs_reg   <= b0_reg[7:0];
            be_reg   <= b1[7:0];
            pc_reg   <= cnt_reg;
            last_reg <= 1'b0;
        end
        else if (ctrl.load_status_out)
        begin
            if (too_many_reg)
            begin
                kind_reg <= psic_pkg::KIND_TOO_MANY;
            end
            else if (total_reg < CW'(3))
            begin
                kind_reg <= psic_pkg::KIND_TOO_FEW;
            end
            else if (cnt_reg != '0)
            begin
                kind_reg <= psic_pkg::KIND_CROSSING;
            end
            else
            begin
                kind_reg <= psic_pkg::KIND_SIMPLE;
            end
            as_reg   <= '0;
            ae_reg   <= '0;
            bs_reg   <= '0;
            be_reg   <= '0;
            pc_reg   <= (too_many_reg || total_reg < CW'(3)) ? '0 : cnt_reg;
            last_reg <= 1'b1;
        end
    end

    always_comb
    begin
        stat.store_full  = total_reg == CW'(psic_pkg::MAX_VERTICES);
        stat.too_many    = too_many_reg;
        stat.too_few     = total_reg < CW'(3);
        stat.pair_done   = a0_next_cnt >= total_reg;
        stat.pair_skip   = (b0_reg >= total_reg) || (b1 == a0_reg) || (b1 == a1);
        stat.crosses     = cross_reg;
        stat.cap_reached = rpt_reg >= RW'(psic_pkg::MAX_REPORTED_PAIRS);
        stat.out_busy    = ov_reg && out_stall;
    end

    assign out_valid   = ov_reg;
    assign kind        = kind_reg;
    assign a_start     = as_reg;
    assign a_end       = ae_reg;
    assign b_start     = bs_reg;
    assign b_end       = be_reg;
    assign pair_count  = pc_reg;
    assign last_result = last_reg;

endmodule

/* src/psic_checker.sv */
// psic_checker: port-level assertions for the polygon crossing checker
// depends on psic_pkg; bound to polygon_self_intersection_checker_core

module psic_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  kind,
    input logic [7:0]  a_start,
    input logic [7:0]  b_start,
    input logic [14:0] pair_count,
    input logic        last_result
);

    // output valid, kind and pair count hold while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(pair_count))
        else $error("output word changed under stall");

    // pair words are never marked last
    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == psic_pkg::KIND_PAIR |-> !last_result)
        else $error("pair word marked last");

    // pair words have edge b after edge a
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == psic_pkg::KIND_PAIR |-> b_start > a_start)
        else $error("edge order wrong");

    // a crossing pair word counts at least one
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == psic_pkg::KIND_PAIR |-> pair_count != 15'd0)
        else $error("pair word with zero count");

    // a simple status word has a zero count and is marked last
    a_simple: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == psic_pkg::KIND_SIMPLE |-> pair_count == 15'd0 && last_result)
        else $error("simple status inconsistent");

endmodule

bind polygon_self_intersection_checker_core psic_checker u_psic_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .a_start     (a_start),
    .b_start     (b_start),
    .pair_count  (pair_count),
    .last_result (last_result)
);

/* sim/testbench.sv */
// testbench: self-checking bench of the polygon self-intersection checker core
// depends on psic_pkg and polygon_self_intersection_checker_core

module testbench;

    // one expected output word
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  a_start;
        logic [7:0]  a_end;
        logic [7:0]  b_start;
        logic [7:0]  b_end;
        logic [14:0] pair_count;
        logic        last_result;
    } result_word_t;

    localparam int WATCHDOG_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic        final_vertex;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [7:0]  a_start;
    logic [7:0]  a_end;
    logic [7:0]  b_start;
    logic [7:0]  b_end;
    logic [14:0] pair_count;
    logic        last_result;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    // predictor state
    logic signed [31:0] poly_x [psic_pkg::MAX_VERTICES];
    logic signed [31:0] poly_y [psic_pkg::MAX_VERTICES];
    int          poly_len;
    bit          poly_overflow;
    bit          mode_report_all;
    logic [31:0] mode_threshold;

    result_word_t pending_results [$];
    int  error_count = 0;
    int  idle_cycles = 0;

    polygon_self_intersection_checker_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .x_coord(x_coord), .y_coord(y_coord), .final_vertex(final_vertex),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .a_start(a_start), .a_end(a_end),
        .b_start(b_start), .b_end(b_end),
        .pair_count(pair_count), .last_result(last_result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // exact crossing test between edge a0->a1 and edge b0->b1, q40.32 products
    function automatic bit edges_intersect(int a0, int a1, int b0, int b1);
        logic signed [33:0]  ax, ay, bx, by, cx, cy;
        logic signed [71:0]  det, nb, na;
        ax = 34'(poly_x[a1]) - 34'(poly_x[a0]);
        ay = 34'(poly_y[a1]) - 34'(poly_y[a0]);
        bx = 34'(poly_x[b1]) - 34'(poly_x[b0]);
        by = 34'(poly_y[b1]) - 34'(poly_y[b0]);
        cx = 34'(poly_x[a0]) - 34'(poly_x[b0]);
        cy = 34'(poly_y[a0]) - 34'(poly_y[b0]);
        det = 72'(ax) * 72'(by) - 72'(bx) * 72'(ay);
        nb  = 72'(ax) * 72'(cy) - 72'(cx) * 72'(ay);
        na  = 72'(bx) * 72'(cy) - 72'(by) * 72'(cx);
        if (det < 0)
        begin
            det = -det;
            nb = -nb;
            na = -na;
        end
        if (det == 0 || det < $signed({40'd0, mode_threshold}))
            return 1'b0;
        if (nb < 0 || nb > det || na < 0 || na > det)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic result_word_t make_word(logic [2:0] k, int as, int ae, int bs,
                                               int be, int cnt, bit last);
        result_word_t w;
        w.kind = k;
        w.a_start = 8'(as);
        w.a_end = 8'(ae);
        w.b_start = 8'(bs);
        w.b_end = 8'(be);
        w.pair_count = 15'(cnt);
        w.last_result = last;
        return w;
    endfunction

    // append one expected word at the tail of the queue
    task automatic queue_result(result_word_t w);
        pending_results.insert(pending_results.size(), w);
    endtask

    // sweep the non-adjacent edge pairs of the loaded polygon, stopping at the first crossing in first-only mode
    task automatic predict_crossings();
        int  found;
        int  listed;
        bit  halt;
        int  b1;
        found = 0;
        listed = 0;
        halt = 1'b0;
        for (int a0 = 0; a0 + 1 < poly_len && !halt; a0++)
        begin
            for (int b0 = a0 + 2; b0 < poly_len && !halt; b0++)
            begin
                b1 = (b0 == poly_len - 1) ? 0 : b0 + 1;
                if (b1 == a0 || b1 == a0 + 1)
                    continue;
                if (!edges_intersect(a0, a0 + 1, b0, b1))
                    continue;
                if (found < 32767)
                    found++;
                if (mode_report_all)
                begin
                    if (listed < psic_pkg::MAX_REPORTED_PAIRS)
                    begin
                        queue_result(make_word(psic_pkg::KIND_PAIR, a0, a0 + 1, b0, b1,
                                               found, 1'b0));
                        listed++;
                    end
                end
                else
                begin
                    queue_result(make_word(psic_pkg::KIND_PAIR, a0, a0 + 1, b0, b1,
                                           found, 1'b0));
                    halt = 1'b1;
                end
            end
        end
        queue_result(make_word(found ? psic_pkg::KIND_CROSSING : psic_pkg::KIND_SIMPLE,
                               0, 0, 0, 0, found, 1'b1));
    endtask

    // update the predictor with one accepted vertex word
    task automatic predict_vertex(logic signed [31:0] vx, logic signed [31:0] vy, bit fin);
        if (poly_len < psic_pkg::MAX_VERTICES)
        begin
            poly_x[poly_len] = vx;
            poly_y[poly_len] = vy;
            poly_len++;
        end
        else
            poly_overflow = 1'b1;
        if (!fin)
            return;
        if (poly_overflow)
            queue_result(make_word(psic_pkg::KIND_TOO_MANY, 0, 0, 0, 0, 0, 1'b1));
        else if (poly_len < 3)
            queue_result(make_word(psic_pkg::KIND_TOO_FEW, 0, 0, 0, 0, 0, 1'b1));
        else
            predict_crossings();
        poly_len = 0;
        poly_overflow = 1'b0;
    endtask

    // send one vertex word after a random gap; valid stays up until the next
    // gap or drain so back-to-back words need only one assignment per edge
    task automatic send_vertex(logic signed [31:0] vx, logic signed [31:0] vy, bit fin);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_coord <= vx;
        y_coord <= vy;
        final_vertex <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_vertex(vx, vy, fin);
    endtask

    // wait for the block to drain before touching registers
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(logic [0:0] idx, logic [31:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == psic_pkg::CFG_REPORT_ALL)
            mode_report_all = value[0];
        else
            mode_threshold = value;
    endtask

    // coordinates: mostly small, sometimes full range to toggle every bit
    function automatic logic signed [31:0] random_coord();
        if ($urandom_range(0, 9) == 0)
            return $signed($urandom());
        return $signed(32'($urandom_range(0, 40) - 20) <<< 16)
               + $signed(32'($urandom_range(0, 3)));
    endfunction

    task automatic send_random_polygon(int n);
        for (int i = 0; i < n; i++)
            send_vertex(random_coord(), random_coord(), i == n - 1);
    endtask

    task automatic test_directed_shapes();
        // square: simple
        send_vertex(32'sh0, 32'sh0, 1'b0);
        send_vertex(32'sh10000, 32'sh0, 1'b0);
        send_vertex(32'sh10000, 32'sh10000, 1'b0);
        send_vertex(32'sh0, 32'sh10000, 1'b1);
        // bow tie: one crossing
        send_vertex(32'sh0, 32'sh0, 1'b0);
        send_vertex(32'sh10000, 32'sh10000, 1'b0);
        send_vertex(32'sh10000, 32'sh0, 1'b0);
        send_vertex(32'sh0, 32'sh10000, 1'b1);
        // too few: one and two vertices
        send_vertex(32'sh7fffffff, 32'sh80000000, 1'b1);
        send_vertex(32'sh80000000, 32'sh7fffffff, 1'b0);
        send_vertex(32'sh7fffffff, 32'sh7fffffff, 1'b1);
        // extreme corners, touching ends included
        send_vertex(32'sh80000000, 32'sh80000000, 1'b0);
        send_vertex(32'sh7fffffff, 32'sh7fffffff, 1'b0);
        send_vertex(32'sh7fffffff, 32'sh80000000, 1'b0);
        send_vertex(32'sh80000000, 32'sh7fffffff, 1'b1);
        // collinear, all on one line: parallel pairs skipped
        send_vertex(32'sh0, 32'sh0, 1'b0);
        send_vertex(32'sh10000, 32'sh10000, 1'b0);
        send_vertex(32'sh20000, 32'sh20000, 1'b0);
        send_vertex(32'sh30000, 32'sh30000, 1'b1);
    endtask

    task automatic test_first_only_mode();
        write_register(psic_pkg::CFG_REPORT_ALL, 32'h0);
        for (int p = 0; p < 3; p++)
            send_random_polygon($urandom_range(4, 9));
        write_register(psic_pkg::CFG_REPORT_ALL, 32'hfffffffe);
        send_random_polygon(6);
        write_register(psic_pkg::CFG_REPORT_ALL, 32'h1);
    endtask

    task automatic test_thresholds();
        write_register(psic_pkg::CFG_THRESHOLD, 32'h0);
        for (int p = 0; p < 2; p++)
            send_random_polygon($urandom_range(4, 8));
        write_register(psic_pkg::CFG_THRESHOLD, 32'hffffffff);
        for (int p = 0; p < 2; p++)
            send_random_polygon($urandom_range(4, 8));
        write_register(psic_pkg::CFG_THRESHOLD, $urandom());
        send_random_polygon(6);
        write_register(psic_pkg::CFG_THRESHOLD, 32'd43);
    endtask

    // zigzag crossed three times by near-horizontal edges so the pair cap is passed
    task automatic test_pair_cap();
        for (int i = 0; i < 24; i++)
            send_vertex(32'(i) <<< 16, (i % 2) ? 32'sh100000 : 32'sh0, 1'b0);
        send_vertex(32'sh180000, 32'sh80000, 1'b0);
        send_vertex(-32'sh10000, 32'sh70000, 1'b0);
        send_vertex(32'sh180000, 32'sh90000, 1'b0);
        send_vertex(-32'sh10000, 32'shA0000, 1'b1);
    endtask

    task automatic test_too_many();
        for (int i = 0; i < psic_pkg::MAX_VERTICES + 1; i++)
            send_vertex(random_coord(), random_coord(), i == psic_pkg::MAX_VERTICES);
    endtask

    task automatic test_random_polygons();
        int sent;
        int n;
        sent = 0;
        while (sent < 24)
        begin
            case ($urandom_range(0, 9))
                0: n = $urandom_range(1, 2);
                1: n = $urandom_range(10, 14);
                default: n = $urandom_range(3, 8);
            endcase
            send_random_polygon(n);
            sent += n;
            if ($urandom_range(0, 3) == 0)
                write_register(psic_pkg::CFG_REPORT_ALL, $urandom());
        end
    endtask

    // random receiver stall ahead of each word
    initial
    begin
        int hold;
        forever
        begin
            hold = $urandom_range(0, 4);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word kind=%0d", $time, kind);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                begin
                    $display("%0t: kind exp %0d got %0d", $time, want.kind, kind);
                    error_count++;
                end
                if (a_start !== want.a_start)
                begin
                    $display("%0t: a_start exp %0d got %0d", $time, want.a_start, a_start);
                    error_count++;
                end
                if (a_end !== want.a_end)
                begin
                    $display("%0t: a_end exp %0d got %0d", $time, want.a_end, a_end);
                    error_count++;
                end
                if (b_start !== want.b_start)
                begin
                    $display("%0t: b_start exp %0d got %0d", $time, want.b_start, b_start);
                    error_count++;
                end
                if (b_end !== want.b_end)
                begin
                    $display("%0t: b_end exp %0d got %0d", $time, want.b_end, b_end);
                    error_count++;
                end
                if (pair_count !== want.pair_count)
                begin
                    $display("%0t: pair_count exp %0d got %0d", $time, want.pair_count,
                             pair_count);
                    error_count++;
                end
                if (last_result !== want.last_result)
                begin
                    $display("%0t: last_result exp %0d got %0d", $time, want.last_result,
                             last_result);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted word on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        poly_len = 0;
        poly_overflow = 1'b0;
        mode_report_all = 1'b1;
        mode_threshold = 32'd43;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        x_coord <= '0;
        y_coord <= '0;
        final_vertex <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= psic_pkg::CFG_REPORT_ALL;
        cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_shapes();
        test_first_only_mode();
        test_thresholds();
        test_pair_cap();
        test_too_many();
        test_random_polygons();

        wait_drained();
        repeat (200) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
